[src/rename_free_list_checkpoint_unit_assert.svh]
// Assertion macros shared by the free list checkpoint unit.
`ifndef RENAME_FREE_LIST_CHECKPOINT_UNIT_ASSERT_SVH
`define RENAME_FREE_LIST_CHECKPOINT_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RFLC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RFLC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/rflc_pkg.sv]
// Types and constants for the rename free list checkpoint unit.
package rflc_pkg;

   localparam int PHYS_REGS_DEF   = 128;
   localparam int ARCH_REGS_DEF   = 32;
   localparam int CHECKPOINTS_DEF = 32;

   localparam int SLOT_W = 5;
   localparam int REG_W  = 7;

   // Width of one leaf of the first-free search
   localparam int GROUP_W = 16;
   localparam int GOFF_W  = 4;

   typedef struct packed {
      logic              flush;
      logic              recover;
      logic [SLOT_W-1:0] recover_slot;
      logic              alloc_request;
      logic              release_valid;
      logic [REG_W-1:0]  release_reg;
      logic              save_valid;
      logic [SLOT_W-1:0] save_slot;
   } req_type;

   typedef struct packed {
      logic             alloc_granted;
      logic [REG_W-1:0] alloc_reg;
   } rsp_type;

endpackage

[src/rflc_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module rflc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/rename_free_list_checkpoint_unit.sv]
// Rename free list: bitmap of physical registers with checkpoint save and restore.
//
// Issue a command by raising start while busy is low. A flush command answers in the
// next cycle and leaves busy low. A recover command passes through the load state,
// which restores the map from the registered checkpoint memory read. A normal command
// (release, allocate, save) passes through the scan and pick states: the release is
// applied in the accept cycle, then a registered two-level first-free search (16-bit
// groups, then the lowest group) finds the grant. Each command produces exactly one
// response, strobed on rsp_valid for one cycle right after the command finishes; the
// receiver must take it then. rsp_item always shows the last grant flag and register
// number. Checkpoints need no clearing pass after reset: a slot never saved reads as
// the reset map.
`include "rename_free_list_checkpoint_unit_assert.svh"

module rename_free_list_checkpoint_unit
   import rflc_pkg::*;
#(
   parameter int PHYS_REGS   = PHYS_REGS_DEF,
   parameter int ARCH_REGS   = ARCH_REGS_DEF,
   parameter int CHECKPOINTS = CHECKPOINTS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int PIDX_W = $clog2(PHYS_REGS);
   localparam int ADDR_W = CHECKPOINTS > 1 ? $clog2(CHECKPOINTS) : 1;
   localparam int NG     = (PHYS_REGS + GROUP_W - 1) / GROUP_W;
   localparam int GI_W   = NG > 1 ? $clog2(NG) : 1;
   localparam int PAD_W  = NG * GROUP_W;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_LOAD = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_PICK = 2'd3;

   logic [1:0]             state_ff, state_in;
   req_type                req_ff, req_in;
   logic [PHYS_REGS-1:0]   free_ff, free_in;
   logic [CHECKPOINTS-1:0] valid_ff, valid_in;
   logic                   grant_ff, grant_in;
   logic [REG_W-1:0]       granted_ff, granted_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [NG-1:0]          grp_found_ff, grp_found_in;
   logic [GOFF_W-1:0]      grp_off_ff [NG];
   logic [GOFF_W-1:0]      grp_off_in [NG];

   logic [PHYS_REGS-1:0] reset_map;
   logic [PAD_W-1:0]     elig;
   logic                 found;
   logic [GI_W-1:0]      grp_sel;
   logic [PIDX_W-1:0]    pick;
   logic [PHYS_REGS-1:0] pick_onehot;
   logic                 grant_now;
   logic [PHYS_REGS-1:0] pick_map;

   logic                 release_ok;
   logic                 recover_ok;
   logic                 save_ok;

   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [PHYS_REGS-1:0] ram_rd_data;

   // Reset map also serves as the architectural-register mask
   always_comb begin
      for (int i = 0; i < PHYS_REGS; i++) begin
         reset_map[i] = (i >= ARCH_REGS);
      end
   end

   // First level of the search: lowest set bit in each group
   assign elig = PAD_W'(free_ff & reset_map);

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         grp_found_in[g] = 1'b0;
         grp_off_in[g]   = '0;
         for (int b = GROUP_W - 1; b >= 0; b--) begin
            if (elig[g * GROUP_W + b]) begin
               grp_found_in[g] = 1'b1;
               grp_off_in[g]   = GOFF_W'(b);
            end
         end
      end
   end

   // Second level: lowest group with a free register
   always_comb begin
      found   = 1'b0;
      grp_sel = '0;
      for (int g = NG - 1; g >= 0; g--) begin
         if (grp_found_ff[g]) begin
            found   = 1'b1;
            grp_sel = GI_W'(g);
         end
      end
   end

   assign pick        = PIDX_W'({grp_sel, grp_off_ff[grp_sel]});
   assign pick_onehot = {{(PHYS_REGS - 1){1'b0}}, 1'b1} << pick;
   assign grant_now   = req_ff.alloc_request && found;
   assign pick_map    = grant_now ? (free_ff & ~pick_onehot) : free_ff;

   assign release_ok = req_item.release_valid && (req_item.release_reg != '0)
                       && (32'(req_item.release_reg) < PHYS_REGS);
   assign recover_ok = 32'(req_ff.recover_slot) < CHECKPOINTS;
   assign save_ok    = req_ff.save_valid && (32'(req_ff.save_slot) < CHECKPOINTS);

   assign ram_rd_en   = (state_ff == ST_IDLE) && start && !req_item.flush
                        && req_item.recover;
   assign ram_rd_addr = ADDR_W'(req_item.recover_slot);
   assign ram_wr_addr = ADDR_W'(req_ff.save_slot);
   assign ram_wr_en   = (state_ff == ST_PICK) && save_ok;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      free_in      = free_ff;
      valid_in     = valid_ff;
      grant_in     = grant_ff;
      granted_in   = granted_ff;
      rsp_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in = req_item;
               if (req_item.flush) begin
                  rsp_valid_in = 1'b1;
               end else if (req_item.recover) begin
                  state_in = ST_LOAD;
               end else begin
                  if (release_ok) begin
                     free_in[PIDX_W'(req_item.release_reg)] = 1'b1;
                  end
                  state_in = ST_SCAN;
               end
            end
         end
         ST_LOAD: begin
            // A slot never saved yields the reset map instead of memory data
            if (recover_ok) begin
               free_in = valid_ff[ADDR_W'(req_ff.recover_slot)] ? ram_rd_data : reset_map;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         ST_SCAN: begin
            state_in = ST_PICK;
         end
         ST_PICK: begin
            grant_in = grant_now;
            free_in  = pick_map;
            if (grant_now) begin
               granted_in = REG_W'(pick);
            end
            if (save_ok) begin
               valid_in[ram_wr_addr] = 1'b1;
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         free_ff      <= reset_map;
         valid_ff     <= '0;
         grant_ff     <= 1'b0;
         granted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_ff      <= free_in;
         valid_ff     <= valid_in;
         grant_ff     <= grant_in;
         granted_ff   <= granted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff       <= req_in;
      grp_found_ff <= grp_found_in;
      grp_off_ff   <= grp_off_in;
   end

   rflc_ram #(
      .WIDTH (PHYS_REGS),
      .DEPTH (CHECKPOINTS)
   ) u_ckpt_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (pick_map),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign busy                   = (state_ff != ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_item.alloc_granted = grant_ff;
   assign rsp_item.alloc_reg     = granted_ff;

   `RFLC_ASSERT_NEXT(a_pick_responds, clock, reset, state_ff == ST_PICK, rsp_valid_ff,
      "pick stage did not produce a response")
   `RFLC_ASSERT_SAME(a_grant_free, clock, reset, (state_ff == ST_PICK) && grant_now,
      free_ff[pick] && (32'(pick) >= ARCH_REGS), "granted register was not free")
   `RFLC_ASSERT_SAME(a_zero_never_free, clock, reset, 1'b1, !free_ff[0],
      "register zero marked free")
   `RFLC_ASSERT_NEXT(a_load_one_cycle, clock, reset, state_ff == ST_LOAD,
      !busy && rsp_valid_ff, "recover did not finish after the memory read")

endmodule
